/* hw/rtl/xoshiro_random_draw_top_macros.svh */
// assertion macros used by the checker file
`ifndef XOSHIRO_RANDOM_DRAW_TOP_MACROS_SVH
`define XOSHIRO_RANDOM_DRAW_TOP_MACROS_SVH

// clocked property, ignored while reset is asserted
`define XRD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked during reset as well
`define XRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/xrd_pkg.sv */
// shared types and constants of the xoshiro random draw block
package xrd_pkg;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned NWORDS   = 4;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned SHL_AMT  = 17;
  localparam int unsigned ROT_AMT  = 45;
  localparam int unsigned HALF_W   = 32;
  localparam int unsigned MUL_STEPS = 32;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned STEP_W   = 6;

  localparam logic [WORD_W-1:0] SEED_WORDS [NWORDS] = '{
    64'hd5a986ae75c9a33b,
    64'h1016d8e3483a8f0f,
    64'h81f9e6260eb8e5df,
    64'hfa9b718d8d0769bf
  };

  typedef enum logic [ACT_W-1:0] {
    ACT_RAW   = 3'd0,
    ACT_SCALE = 3'd1,
    ACT_MOD   = 3'd2,
    ACT_READ  = 3'd3,
    ACT_WRITE = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SERIAL,
    ST_DONE
  } state_e;

  // generator control
  typedef struct packed {
    logic             adv;
    logic             wr;
    logic [IDX_W-1:0] idx;
  } gen_cmd_t;

  // serial unit control
  typedef struct packed {
    logic start;
    logic is_div;
  } ser_cmd_t;

endpackage

/* hw/rtl/xrd_gen.sv */
// xoshiro256+ state words, update and word access
module xrd_gen (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  xrd_pkg::gen_cmd_t         cmd_i,
  input  logic [xrd_pkg::WORD_W-1:0] seed_i,
  output logic [xrd_pkg::WORD_W-1:0] draw_o,
  output logic [xrd_pkg::WORD_W-1:0] rd_word_o
);
  import xrd_pkg::*;

  logic [WORD_W-1:0] words_q [NWORDS];
  logic [WORD_W-1:0] words_d [NWORDS];
  logic [WORD_W-1:0] t;
  logic [WORD_W-1:0] x3;

  always_comb begin
    t          = words_q[1] << SHL_AMT;
    words_d[2] = words_q[2] ^ words_q[0];
    x3         = words_q[3] ^ words_q[1];
    words_d[1] = words_q[1] ^ words_d[2];
    words_d[0] = words_q[0] ^ x3;
    words_d[2] = words_d[2] ^ t;
    words_d[3] = (x3 << ROT_AMT) | (x3 >> (WORD_W - ROT_AMT));
  end

  // drawn word is taken from the updated state
  assign draw_o    = words_d[0] + words_d[3];
  assign rd_word_o = words_q[cmd_i.idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NWORDS; i++) words_q[i] <= SEED_WORDS[i];
    end else if (cmd_i.adv) begin
      for (int i = 0; i < NWORDS; i++) words_q[i] <= words_d[i];
    end else if (cmd_i.wr) begin
      words_q[cmd_i.idx] <= seed_i;
    end
  end

endmodule

/* hw/rtl/xrd_serial.sv */
// bit-serial shift-add multiplier and restoring remainder unit
module xrd_serial (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  xrd_pkg::ser_cmd_t          cmd_i,
  input  logic [xrd_pkg::WORD_W-1:0] opnd_i,
  input  logic [xrd_pkg::WORD_W-1:0] bound_i,
  output logic                       done_o,
  output logic [xrd_pkg::WORD_W-1:0] result_o
);
  import xrd_pkg::*;

  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_STEPS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

  logic              run_q, div_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [WORD_W-1:0] shift_q, acc_q, bnd_q;

  logic [WORD_W:0]   trial;
  logic              fits;
  logic [WORD_W-1:0] div_next, mul_next;

  always_comb begin
    trial    = {acc_q, shift_q[WORD_W-1]};
    fits     = trial >= {1'b0, bnd_q};
    div_next = fits ? WORD_W'(trial - {1'b0, bnd_q}) : trial[WORD_W-1:0];
    mul_next = {acc_q[WORD_W-2:0], 1'b0} + (shift_q[WORD_W-1] ? bnd_q : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        run_q <= 1'b1;
        div_q <= cmd_i.is_div;
        cnt_q <= cmd_i.is_div ? DIV_LAST : MUL_LAST;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      // multiplier bits start at bit 31, dividend bits at bit 63
      shift_q <= cmd_i.is_div ? opnd_i : {opnd_i[HALF_W-1:0], {HALF_W{1'b0}}};
      acc_q   <= '0;
      bnd_q   <= bound_i;
    end else if (run_q) begin
      shift_q <= {shift_q[WORD_W-2:0], 1'b0};
      acc_q   <= div_q ? div_next : mul_next;
    end
  end

  assign done_o   = done_q;
  assign result_o = div_q ? acc_q : {{HALF_W{1'b0}}, acc_q[WORD_W-1:HALF_W]};

endmodule

/* hw/rtl/xoshiro_random_draw_top.sv */
// top level of the xoshiro random draw block
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+--------------------------------------
//   in      | to block  | in_valid_i / in_stall_o    | action_i bound_i word_index_i seed_word_i
//   out     | from block| out_valid_o / out_stall_i  | value_o
//
// raw draw, read, write and unused actions: result goes to res_q, then to the output register
// scaled draw: passes through the 32 one-bit shift-add steps of the serial unit
// modulo draw with nonzero bound: passes through the 64 one-bit remainder steps
// one item in flight; in_stall_o is high from the input transfer until the result
//   has moved into the output register, which frees the block for the next item
// reset loads the four fixed seed words at once; no clearing pass
// a stalled output lets one more item finish, then that item's result stalls the input
module xoshiro_random_draw_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [xrd_pkg::ACT_W-1:0]   action_i,
  input  logic [xrd_pkg::WORD_W-1:0]  bound_i,
  input  logic [xrd_pkg::IDX_W-1:0]   word_index_i,
  input  logic [xrd_pkg::WORD_W-1:0]  seed_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [xrd_pkg::WORD_W-1:0]  value_o
);
  import xrd_pkg::*;

  state_e            state_q, state_d;
  logic [WORD_W-1:0] res_q, res_d;
  logic              out_valid_q;
  logic [WORD_W-1:0] out_value_q;

  gen_cmd_t          gen_cmd;
  ser_cmd_t          ser_cmd;
  logic [WORD_W-1:0] draw, rd_word, ser_result;
  logic              ser_done;

  logic              in_xfer;
  logic              out_free;
  logic              out_load;

  // state words and the xoshiro256+ update
  xrd_gen u_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (gen_cmd),
    .seed_i    (seed_word_i),
    .draw_o    (draw),
    .rd_word_o (rd_word)
  );

  // one bit per cycle multiply and remainder
  xrd_serial u_serial (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (ser_cmd),
    .opnd_i   (draw),
    .bound_i  (bound_i),
    .done_o   (ser_done),
    .result_o (ser_result)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  // output register can take a result when empty or when its result leaves now
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    res_d          = res_q;
    gen_cmd.adv    = 1'b0;
    gen_cmd.wr     = 1'b0;
    gen_cmd.idx    = word_index_i;
    ser_cmd.start  = 1'b0;
    ser_cmd.is_div = 1'b0;
    out_load       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_DONE;
          case (action_e'(action_i))
            ACT_RAW: begin
              gen_cmd.adv = 1'b1;
              res_d       = draw;
            end
            ACT_SCALE: begin
              // a zero bound runs through the multiplier and gives zero
              gen_cmd.adv   = 1'b1;
              ser_cmd.start = 1'b1;
              state_d       = ST_SERIAL;
            end
            ACT_MOD: begin
              gen_cmd.adv = 1'b1;
              if (bound_i == '0) begin
                // zero bound hands back the raw draw
                res_d = draw;
              end else begin
                ser_cmd.start  = 1'b1;
                ser_cmd.is_div = 1'b1;
                state_d        = ST_SERIAL;
              end
            end
            ACT_READ: begin
              res_d = rd_word;
            end
            ACT_WRITE: begin
              gen_cmd.wr = 1'b1;
              res_d      = '0;
            end
            default: begin
              // unused action codes leave the state alone and answer zero
              res_d = '0;
            end
          endcase
        end
      end
      ST_SERIAL: begin
        if (ser_done) begin
          res_d   = ser_result;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      out_value_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;

endmodule

/* hw/rtl/xrd_checker.sv */
// port-level checks of the xoshiro random draw block and their binding
`include "xoshiro_random_draw_top_macros.svh"

module xrd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [xrd_pkg::WORD_W-1:0] value_o
);

  // a stalled result stays offered
  `XRD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  // a stalled result keeps its value
  `XRD_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(value_o), "result changed while stalled")
  // one item at a time: the input side closes after each transfer
  `XRD_ASSERT(a_in_busy, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "second item taken while busy")
  // a new result appears only at the end of an item's work
  `XRD_ASSERT(a_out_rise, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o), "result without an item in work")
  // no result is offered during reset
  `XRD_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o, "result offered in reset")

endmodule

bind xoshiro_random_draw_top xrd_checker u_xrd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_o     (value_o)
);
